// File: hw/rtl/ple_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the positional list engine.
// No dependencies; imported by ple_if, ple_seq and the core.
package ple_pkg;

    localparam int VAL_W   = 32;
    localparam int POS_W   = 8;
    localparam int CMD_W   = 3;
    localparam int ST_W    = 2;
    localparam int CNT_O_W = 9;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EMPTY  = 3'd4;

    localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic               found;
        logic [POS_W-1:0]   found_index;
        logic               is_empty;
        logic [CNT_O_W-1:0] entry_count;
    } t_result;

endpackage

// File: hw/rtl/ple_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for commands and results.
// Depends on ple_pkg for field widths.
interface ple_cmd_if import ple_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;

    modport source (output valid, output cmd, output value, output position, input ready);
    modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

interface ple_res_if import ple_pkg::*;;
    logic               valid;
    logic               ready;
    logic [ST_W-1:0]    status;
    logic               found;
    logic [POS_W-1:0]   found_index;
    logic               is_empty;
    logic [CNT_O_W-1:0] entry_count;

    modport source (output valid, output status, output found, output found_index,
                    output is_empty, output entry_count, input ready);
    modport sink   (input valid, input status, input found, input found_index,
                    input is_empty, input entry_count, output ready);
endinterface

// File: hw/rtl/ple_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/ple_seq.sv
`timescale 1ns / 1ps
// Command sequencer: one pointer/compare unit walks the entry RAM for
// shift and search, one entry per cycle. Depends on ple_pkg.
module ple_seq import ple_pkg::*; #(
    parameter int CAPACITY = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  t_req                        i_req,
    output logic                        o_idle,
    output logic                        o_res_valid,
    output t_result                     o_res,
    input  logic                        i_res_take,
    output logic                        o_ram_we,
    output logic [$clog2(CAPACITY)-1:0] o_ram_waddr,
    output logic [VAL_W-1:0]            o_ram_wdata,
    output logic [$clog2(CAPACITY)-1:0] o_ram_raddr,
    input  logic [VAL_W-1:0]            i_ram_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_SEARCH = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    t_req            r_req, n_req;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_ptr, n_ptr;
    logic [CW-1:0]   r_tgt, n_tgt;
    logic            r_pend, n_pend;
    logic            r_more, n_more;
    logic            r_found, n_found;
    logic [CW-1:0]   r_fidx, n_fidx;
    logic [ST_W-1:0] r_status, n_status;

    logic            ins;
    logic            pos_bad;
    logic            full;
    logic            last;
    logic [CW-1:0]   waddr_full;
    logic [CW-1:0]   raddr_full;
    logic [CW+CNT_O_W-1:0] count_ext;
    logic [CW+POS_W-1:0]   fidx_ext;

    assign ins     = (r_req.cmd == CMD_INSERT);
    assign pos_bad = (PW'(r_req.position) >= PW'(r_count));
    assign full    = (r_count == CW'(CAPACITY));
    assign last    = ins ? (PW'(r_ptr) == PW'(r_req.position))
                         : (r_ptr == r_count - CW'(1));

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_tgt       = r_tgt;
        n_pend      = r_pend;
        n_more      = r_more;
        n_found     = r_found;
        n_fidx      = r_fidx;
        n_status    = r_status;
        o_ram_we    = 1'b0;
        waddr_full  = r_tgt;
        o_ram_wdata = i_ram_rdata;
        raddr_full  = r_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = ST_DONE;
                n_found  = 1'b0;
                n_fidx   = '0;
                n_pend   = 1'b0;
                n_state  = S_RESULT;
                unique case (r_req.cmd)
                    CMD_APPEND: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_ram_we    = 1'b1;
                            waddr_full  = r_count;
                            o_ram_wdata = r_req.value;
                            n_count     = r_count + CW'(1);
                        end
                    end
                    CMD_INSERT: begin
                        if (pos_bad) begin
                            n_status = ST_BADPOS;
                        end else if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            // walk down from the tail, moving each entry up by one
                            n_ptr   = r_count - CW'(1);
                            n_more  = 1'b1;
                            n_state = S_SHIFT;
                        end
                    end
                    CMD_REMOVE: begin
                        if (pos_bad) begin
                            n_status = ST_BADPOS;
                        end else begin
                            n_ptr   = CW'(PW'(r_req.position) + PW'(1));
                            n_more  = (PW'(r_req.position) + PW'(1) < PW'(r_count));
                            n_state = S_SHIFT;
                        end
                    end
                    CMD_SEARCH: begin
                        n_ptr   = '0;
                        n_more  = (r_count != '0);
                        n_state = S_SEARCH;
                    end
                    default: begin
                    end
                endcase
            end
            S_SHIFT: begin
                // drain the entry read last cycle into its new slot
                if (r_pend) begin
                    o_ram_we    = 1'b1;
                    waddr_full  = ins ? (r_tgt + CW'(1)) : (r_tgt - CW'(1));
                    o_ram_wdata = i_ram_rdata;
                end
                if (r_more) begin
                    n_pend = 1'b1;
                    n_tgt  = r_ptr;
                    if (last) begin
                        n_more = 1'b0;
                    end else begin
                        n_ptr = ins ? (r_ptr - CW'(1)) : (r_ptr + CW'(1));
                    end
                end else begin
                    n_pend = 1'b0;
                end
                if (!r_more && !r_pend) begin
                    if (ins) begin
                        o_ram_we    = 1'b1;
                        waddr_full  = CW'(PW'(r_req.position));
                        o_ram_wdata = r_req.value;
                        n_count     = r_count + CW'(1);
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                    n_state = S_RESULT;
                end
            end
            S_SEARCH: begin
                if (r_pend && (i_ram_rdata == r_req.value)) begin
                    n_found = 1'b1;
                    n_fidx  = r_tgt;
                    n_pend  = 1'b0;
                    n_state = S_RESULT;
                end else if (!r_more) begin
                    n_pend  = 1'b0;
                    n_state = S_RESULT;
                end else begin
                    n_pend = 1'b1;
                    n_tgt  = r_ptr;
                    if (last) begin
                        n_more = 1'b0;
                    end else begin
                        n_ptr = r_ptr + CW'(1);
                    end
                end
            end
            S_RESULT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_more  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_more  <= n_more;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_ptr    <= n_ptr;
        r_tgt    <= n_tgt;
        r_found  <= n_found;
        r_fidx   <= n_fidx;
        r_status <= n_status;
    end

    assign o_ram_waddr = waddr_full[AW-1:0];
    assign o_ram_raddr = raddr_full[AW-1:0];

    assign count_ext = {{CNT_O_W{1'b0}}, r_count};
    assign fidx_ext  = {{POS_W{1'b0}}, r_fidx};

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESULT);

    always_comb begin
        o_res.status      = r_status;
        o_res.found       = r_found;
        o_res.found_index = fidx_ext[POS_W-1:0];
        o_res.is_empty    = (r_count == '0);
        o_res.entry_count = count_ext[CNT_O_W-1:0];
    end

endmodule

// File: hw/rtl/positional_list_engine_core.sv
`timescale 1ns / 1ps
// Positional list engine: append, insert, remove, search, empty query.
// Append, empty query and ignored or refused commands finish in the execute step; insert,
// remove and search then walk the stored entries, one entry per cycle (search stops at a match).
// One transaction at a time; the next is accepted once the result is registered.
// Reset (synchronous, active low) empties the list; entry storage is not cleared.
// Depends on ple_pkg, ple_if, ple_ram and ple_seq.
module positional_list_engine_core import ple_pkg::*; #(
    parameter int CAPACITY = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ple_cmd_if.sink    i_cmd,
    ple_res_if.source  o_res
);

    localparam int AW = $clog2(CAPACITY);

    t_req             req;
    t_result          seq_res;
    t_result          r_out;
    logic             r_out_valid;
    logic             seq_idle;
    logic             seq_res_valid;
    logic             res_take;
    logic             start;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [VAL_W-1:0] ram_wdata;
    logic [VAL_W-1:0] ram_rdata;

    assign i_cmd.ready = seq_idle;
    assign start       = i_cmd.valid && seq_idle;

    always_comb begin
        req.cmd      = i_cmd.cmd;
        req.value    = i_cmd.value;
        req.position = i_cmd.position;
    end

    // move the finished result into the output register when it is free
    assign res_take = seq_res_valid && (!r_out_valid || o_res.ready);

    ple_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req),
        .o_idle      (seq_idle),
        .o_res_valid (seq_res_valid),
        .o_res       (seq_res),
        .i_res_take  (res_take),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    ple_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= seq_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out.status;
    assign o_res.found       = r_out.found;
    assign o_res.found_index = r_out.found_index;
    assign o_res.is_empty    = r_out.is_empty;
    assign o_res.entry_count = r_out.entry_count;

endmodule
